/* hdl/rvm_pkg.sv */
// rvm_pkg: shared constants and types for the ridge/valley marker
// frame limits, output codes, map mark kinds, event queue beat types
// no dependencies
`default_nettype none

package rvm_pkg;

    localparam int MAX_WIDTH  = 512;
    localparam int MAX_HEIGHT = 512;

    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int ROW_W  = $clog2(MAX_HEIGHT);
    localparam int MAP_AW = ROW_W + COL_W;
    localparam int SIZE_W = 10;
    localparam int PIX_W  = 8;

    localparam logic [SIZE_W-1:0] SIZE_MIN   = SIZE_W'(3);
    localparam logic [SIZE_W-1:0] WIDTH_MAX  = SIZE_W'(MAX_WIDTH);
    localparam logic [SIZE_W-1:0] HEIGHT_MAX = SIZE_W'(MAX_HEIGHT);

    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

    typedef logic signed [2:0] code_t;

    localparam code_t CODE_NONE         = 3'b000;
    localparam code_t CODE_ROW_PEAK     = 3'b001;
    localparam code_t CODE_ROW_VALLEY   = 3'b111;
    localparam code_t CODE_COL_PEAK     = 3'b010;
    localparam code_t CODE_COL_VALLEY   = 3'b110;
    localparam code_t CODE_PEAK_CROSS   = 3'b011;
    localparam code_t CODE_VALLEY_CROSS = 3'b101;
    localparam code_t CODE_MIXED        = 3'b100;

    typedef enum logic [1:0] {
        MARK_NONE   = 2'b00,
        MARK_PEAK   = 2'b01,
        MARK_VALLEY = 2'b10
    } mark_t;

    typedef struct packed {
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        code_t            code;
        logic             last;
    } rvm_event_t;

    typedef struct packed {
        logic       valid;
        rvm_event_t ev;
    } rvm_push_t;

    localparam int EVQ_DEPTH = 8;
    localparam int EVQ_AW    = $clog2(EVQ_DEPTH);

endpackage

`default_nettype wire

/* hdl/ridge_valley_marker_unit.sv */
// ridge_valley_marker_unit: row/column peak and valley marker over a raster pixel stream
// order: a pixel's events pass the s1 and s2 registers into the event queue, row event first
// a pixel waits until its predecessor leaves s1, due to the single write port of the mark map
//   (entry clear plus row mark per pixel) and the column state read then write back
// reset: counters, row state, pipeline and event queue cleared, frame size 512 x 512;
//   mark map and column memories are not initialized, each map entry clears as its pixel arrives
// depends on rvm_pkg and rvm_event_fifo
`default_nettype none

module ridge_valley_marker_unit
    import rvm_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_write,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [SIZE_W-1:0]    cfg_data,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [PIX_W-1:0]     pixel,
    input  logic                 frame_start,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [ROW_W-1:0]     mark_row,
    output logic [COL_W-1:0]     mark_col,
    output logic signed [2:0]    mark_code,
    output logic                 last
);

    typedef struct packed {
        logic [PIX_W-1:0] line;
        logic [PIX_W-1:0] prev;
        logic [ROW_W-1:0] run;
    } col_entry_t;

    localparam logic [EVQ_AW+1:0] EVQ_LIMIT = (EVQ_AW+2)'(EVQ_DEPTH - 2);

    function automatic logic [SIZE_W-1:0] clamp_size(
        input logic [SIZE_W-1:0] v,
        input logic [SIZE_W-1:0] maxv
    );
        logic [SIZE_W-1:0] res;
        begin
            res = v;
            if (v < SIZE_MIN)
            begin
                res = SIZE_MIN;
            end
            else if (v > maxv)
            begin
                res = maxv;
            end
            return res;
        end
    endfunction

    function automatic code_t row_code(input mark_t kind);
        code_t res;
        begin
            case (kind)
                MARK_PEAK:   res = CODE_ROW_PEAK;
                MARK_VALLEY: res = CODE_ROW_VALLEY;
                default:     res = CODE_NONE;
            endcase
            return res;
        end
    endfunction

    function automatic code_t col_code(input mark_t kind, input mark_t old);
        code_t res;
        begin
            res = CODE_NONE;
            case (kind)
                MARK_PEAK:
                begin
                    case (old)
                        MARK_PEAK:   res = CODE_PEAK_CROSS;
                        MARK_VALLEY: res = CODE_MIXED;
                        default:     res = CODE_COL_PEAK;
                    endcase
                end
                MARK_VALLEY:
                begin
                    case (old)
                        MARK_VALLEY: res = CODE_VALLEY_CROSS;
                        MARK_PEAK:   res = CODE_MIXED;
                        default:     res = CODE_COL_VALLEY;
                    endcase
                end
                default: res = CODE_NONE;
            endcase
            return res;
        end
    endfunction

    // configuration and position
    logic [SIZE_W-1:0] frame_width_reg;
    logic [SIZE_W-1:0] frame_height_reg;
    logic [SIZE_W-1:0] width_eff;
    logic [SIZE_W-1:0] height_eff;
    logic [COL_W-1:0]  col_cnt_reg;
    logic [COL_W-1:0]  col_cnt_next;
    logic [ROW_W-1:0]  row_cnt_reg;
    logic [ROW_W-1:0]  row_cnt_next;
    logic [SIZE_W-1:0] col_base;
    logic [SIZE_W-1:0] row_base;
    logic [SIZE_W-1:0] row_inc;
    logic [SIZE_W-1:0] col_plus;
    logic [SIZE_W-1:0] row_plus;
    logic [COL_W-1:0]  cur_c;
    logic [ROW_W-1:0]  cur_r;
    logic              accept;

    // row scan
    logic [PIX_W-1:0]  row_prev_reg;
    logic [PIX_W-1:0]  row_prev_next;
    logic [PIX_W-1:0]  held_reg;
    logic [COL_W-1:0]  row_run_reg;
    logic [COL_W-1:0]  row_run_next;
    mark_t             row_kind;
    logic [COL_W-1:0]  row_mc;

    // first stage
    logic              s1_valid_reg;
    logic [PIX_W-1:0]  s1_pixel_reg;
    logic [ROW_W-1:0]  s1_r_reg;
    logic [COL_W-1:0]  s1_c_reg;
    mark_t             s1_row_kind_reg;
    logic [COL_W-1:0]  s1_mc_reg;
    mark_t             col_kind;
    logic [ROW_W-1:0]  col_mr;
    col_entry_t        col_wdata;

    // second stage
    logic              s2_valid_reg;
    logic [ROW_W-1:0]  s2_r_reg;
    logic [COL_W-1:0]  s2_c_reg;
    mark_t             s2_row_kind_reg;
    logic [COL_W-1:0]  s2_mc_reg;
    mark_t             s2_col_kind_reg;
    logic [ROW_W-1:0]  s2_mr_reg;

    // memories
    col_entry_t        col_mem [MAX_WIDTH];
    col_entry_t        col_rdata_reg;
    mark_t             map_mem [MAX_WIDTH*MAX_HEIGHT];
    mark_t             map_rdata_reg;
    logic              map_we;
    logic [MAP_AW-1:0] map_waddr;
    mark_t             map_wdata;
    logic [MAP_AW-1:0] map_raddr;

    // event queue
    rvm_push_t         push_a;
    rvm_push_t         push_b;
    rvm_event_t        evq_head;
    logic              evq_not_empty;
    logic [EVQ_AW:0]   evq_count;
    logic [EVQ_AW+1:0] evq_need;
    logic              take;

    assign width_eff  = clamp_size(frame_width_reg, WIDTH_MAX);
    assign height_eff = clamp_size(frame_height_reg, HEIGHT_MAX);

    assign evq_need = {1'b0, evq_count} + {{EVQ_AW{1'b0}}, s2_valid_reg, 1'b0};
    assign in_stall = s1_valid_reg || (evq_need > EVQ_LIMIT);
    assign accept   = in_valid && !in_stall;

    // position of the incoming pixel
    always_comb
    begin
        col_base = frame_start ? '0 : SIZE_W'(col_cnt_reg);
        row_base = frame_start ? '0 : SIZE_W'(row_cnt_reg);
        if (col_base >= width_eff)
        begin
            cur_c   = '0;
            row_inc = row_base + SIZE_W'(1);
        end
        else
        begin
            cur_c   = col_base[COL_W-1:0];
            row_inc = row_base;
        end
        cur_r = (row_inc >= height_eff) ? '0 : row_inc[ROW_W-1:0];

        col_plus = SIZE_W'(cur_c) + SIZE_W'(1);
        row_plus = SIZE_W'(cur_r) + SIZE_W'(1);
        if (col_plus >= width_eff)
        begin
            col_cnt_next = '0;
            row_cnt_next = (row_plus >= height_eff) ? '0 : row_plus[ROW_W-1:0];
        end
        else
        begin
            col_cnt_next = col_plus[COL_W-1:0];
            row_cnt_next = cur_r;
        end
    end

    // row scan, centre is the held pixel
    always_comb
    begin
        row_kind      = MARK_NONE;
        row_prev_next = row_prev_reg;
        row_run_next  = row_run_reg;
        row_mc        = cur_c - COL_W'(1) - (row_run_reg >> 1);
        if (cur_c == '0)
        begin
            row_prev_next = pixel;
            row_run_next  = '0;
        end
        else if (cur_c >= COL_W'(2))
        begin
            if ((row_prev_reg < held_reg) && (held_reg > pixel))
            begin
                row_kind = MARK_PEAK;
            end
            else if ((row_prev_reg > held_reg) && (held_reg < pixel))
            begin
                row_kind = MARK_VALLEY;
            end
            if (held_reg == pixel)
            begin
                row_run_next = row_run_reg + COL_W'(1);
            end
            else
            begin
                row_run_next  = '0;
                row_prev_next = held_reg;
            end
        end
    end

    // column scan on the column state read back
    always_comb
    begin
        col_kind       = MARK_NONE;
        col_wdata.line = s1_pixel_reg;
        col_wdata.prev = col_rdata_reg.prev;
        col_wdata.run  = col_rdata_reg.run;
        col_mr         = s1_r_reg - ROW_W'(1) - (col_rdata_reg.run >> 1);
        if (s1_r_reg == '0)
        begin
            col_wdata.prev = s1_pixel_reg;
            col_wdata.run  = '0;
        end
        else if (s1_r_reg != ROW_W'(1))
        begin
            if ((col_rdata_reg.prev < col_rdata_reg.line)
                && (col_rdata_reg.line > s1_pixel_reg))
            begin
                col_kind = MARK_PEAK;
            end
            else if ((col_rdata_reg.prev > col_rdata_reg.line)
                     && (col_rdata_reg.line < s1_pixel_reg))
            begin
                col_kind = MARK_VALLEY;
            end
            if (col_rdata_reg.line == s1_pixel_reg)
            begin
                col_wdata.run = col_rdata_reg.run + ROW_W'(1);
            end
            else
            begin
                col_wdata.prev = col_rdata_reg.line;
                col_wdata.run  = '0;
            end
        end
    end

    // map port: row mark in the cycle after the beat, entry clear on the beat
    always_comb
    begin
        map_we    = 1'b0;
        map_waddr = {cur_r, cur_c};
        map_wdata = MARK_NONE;
        if (s1_valid_reg && (s1_row_kind_reg != MARK_NONE))
        begin
            map_we    = 1'b1;
            map_waddr = {s1_r_reg, s1_mc_reg};
            map_wdata = s1_row_kind_reg;
        end
        else if (accept)
        begin
            map_we = 1'b1;
        end
        map_raddr = {col_mr, s1_c_reg};
    end

    always_ff @(posedge clk)
    begin
        if (map_we)
        begin
            map_mem[map_waddr] <= map_wdata;
        end
        map_rdata_reg <= map_mem[map_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (s1_valid_reg)
        begin
            col_mem[s1_c_reg] <= col_wdata;
        end
        col_rdata_reg <= col_mem[cur_c];
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= WIDTH_MAX;
            frame_height_reg <= HEIGHT_MAX;
            col_cnt_reg      <= '0;
            row_cnt_reg      <= '0;
            row_prev_reg     <= '0;
            held_reg         <= '0;
            row_run_reg      <= '0;
            s1_valid_reg     <= 1'b0;
            s2_valid_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                unique case (cfg_index)
                    REG_FRAME_WIDTH:  frame_width_reg  <= cfg_data;
                    REG_FRAME_HEIGHT: frame_height_reg <= cfg_data;
                    default:          ;
                endcase
            end
            if (accept)
            begin
                col_cnt_reg  <= col_cnt_next;
                row_cnt_reg  <= row_cnt_next;
                row_prev_reg <= row_prev_next;
                held_reg     <= pixel;
                row_run_reg  <= row_run_next;
            end
            s1_valid_reg <= accept;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    // pipeline payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_pixel_reg    <= pixel;
            s1_r_reg        <= cur_r;
            s1_c_reg        <= cur_c;
            s1_row_kind_reg <= row_kind;
            s1_mc_reg       <= row_mc;
        end
        if (s1_valid_reg)
        begin
            s2_r_reg        <= s1_r_reg;
            s2_c_reg        <= s1_c_reg;
            s2_row_kind_reg <= s1_row_kind_reg;
            s2_mc_reg       <= s1_mc_reg;
            s2_col_kind_reg <= col_kind;
            s2_mr_reg       <= col_mr;
        end
    end

    // events of one pixel, row event first
    always_comb
    begin
        push_a.valid   = s2_valid_reg && (s2_row_kind_reg != MARK_NONE);
        push_a.ev.row  = s2_r_reg;
        push_a.ev.col  = s2_mc_reg;
        push_a.ev.code = row_code(s2_row_kind_reg);
        push_a.ev.last = (s2_col_kind_reg == MARK_NONE);

        push_b.valid   = s2_valid_reg && (s2_col_kind_reg != MARK_NONE);
        push_b.ev.row  = s2_mr_reg;
        push_b.ev.col  = s2_c_reg;
        push_b.ev.code = col_code(s2_col_kind_reg, map_rdata_reg);
        push_b.ev.last = 1'b1;
    end

    assign take = out_valid && !out_stall;

    rvm_event_fifo u_event_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push_a    (push_a),
        .push_b    (push_b),
        .take      (take),
        .head      (evq_head),
        .not_empty (evq_not_empty),
        .count     (evq_count)
    );

    assign out_valid = evq_not_empty;
    assign mark_row  = evq_head.row;
    assign mark_col  = evq_head.col;
    assign mark_code = evq_head.code;
    assign last      = evq_head.last;

    // queue has room for both events of the pixel in flight
    a_evq_room: assert property (@(posedge clk) disable iff (!rst_n)
        s2_valid_reg |-> (evq_need <= EVQ_LIMIT + (EVQ_AW+2)'(2)))
        else $error("event queue room check violated");

    // a pixel is never accepted back to back with another
    a_pixel_spacing: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> in_stall)
        else $error("pixel accepted on consecutive cycles");

    // the second event of a pixel is ready right behind the first
    a_event_pair: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_stall && !last) |=> out_valid)
        else $error("event beat without last not followed by its partner");

endmodule

`default_nettype wire

/* hdl/rvm_event_fifo.sv */
// rvm_event_fifo: output event queue, up to two pushes and one pop per cycle
// depends on rvm_pkg (rvm_event_t, rvm_push_t, EVQ_DEPTH)
`default_nettype none

module rvm_event_fifo
    import rvm_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  rvm_push_t         push_a,
    input  rvm_push_t         push_b,
    input  logic              take,
    output rvm_event_t        head,
    output logic              not_empty,
    output logic [EVQ_AW:0]   count
);

    rvm_event_t        slot_mem [EVQ_DEPTH];
    logic [EVQ_AW-1:0] wr_ptr_reg;
    logic [EVQ_AW-1:0] wr_ptr_next;
    logic [EVQ_AW-1:0] rd_ptr_reg;
    logic [EVQ_AW-1:0] rd_ptr_next;
    logic [EVQ_AW:0]   count_reg;
    logic [EVQ_AW:0]   count_next;
    logic              pop;
    logic              wr0_en;
    logic              wr1_en;
    rvm_event_t        wr0_data;
    logic [EVQ_AW:0]   n_push;

    assign pop       = take && (count_reg != '0);
    assign wr0_en    = push_a.valid || push_b.valid;
    assign wr1_en    = push_a.valid && push_b.valid;
    assign wr0_data  = push_a.valid ? push_a.ev : push_b.ev;
    assign n_push    = (EVQ_AW+1)'(wr0_en) + (EVQ_AW+1)'(wr1_en);

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + n_push[EVQ_AW-1:0];
        rd_ptr_next = rd_ptr_reg + EVQ_AW'(pop);
        count_next  = count_reg + n_push - (EVQ_AW+1)'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr0_en)
        begin
            slot_mem[wr_ptr_reg] <= wr0_data;
        end
        if (wr1_en)
        begin
            slot_mem[wr_ptr_reg + EVQ_AW'(1)] <= push_b.ev;
        end
    end

    assign head      = slot_mem[rd_ptr_reg];
    assign not_empty = (count_reg != '0);
    assign count     = count_reg;

endmodule

`default_nettype wire
